@@ sv/quadratic_root_solver_assert.svh @@
// Assertion macros for the quadratic root solver.
// Depends on nothing; included by quadratic_root_solver.sv.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication
`define QRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver.
// No dependencies.
package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int OUT_WIDTH      = 34;

   typedef enum logic [1:0] {
      KIND_REPEAT  = 2'd0,
      KIND_TWO     = 2'd1,
      KIND_COMPLEX = 2'd2,
      KIND_DEGEN   = 2'd3
   } kind_type;

endpackage

@@ sv/quadratic_root_solver.sv @@
// Quadratic root solver: fully pipelined discriminant, square root and divides.
// Depends on qrs_pkg and quadratic_root_solver_assert.svh.
//
//   channel | dir | fields                                       | handshake
//   req     | in  | coef_quad, coef_lin, coef_const              | req_valid/req_ready
//   rsp     | out | root_kind, first_value, second_value         | rsp_valid/rsp_ready
//
// One transfer enters per cycle while the output is not stalled. The pipe
// has COEF_WIDTH+FRAC_BITS+1 square root stages, COEF_WIDTH+FRAC_BITS+2
// divider stages and five more (capture, products, discriminant,
// numerator, output); the root and divide chains take one bit per stage.
// Synchronous reset clears all valid bits; payload registers are not reset.
// A stall at rsp freezes the whole pipe; req_ready drops only while the
// output register holds an untaken result.
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_quad,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_lin,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_const,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_root_kind,
   output logic signed [qrs_pkg::OUT_WIDTH-1:0]  rsp_first_value,
   output logic signed [qrs_pkg::OUT_WIDTH-1:0]  rsp_second_value
);

   localparam int W   = COEF_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int OW  = qrs_pkg::OUT_WIDTH;
   localparam int DCW = 2*W + 2;          // discriminant, signed
   localparam int MW  = 2*W + 1;          // |disc|
   localparam int SW  = MW + 2*F + 1;     // root operand, even
   localparam int RW  = SW / 2;           // root bits
   localparam int PW  = W + F + 1;        // -b*2^F, signed
   localparam int NW  = W + F + 2;        // numerator magnitude
   localparam int NSW = NW + 1;
   localparam int DW  = W + 1;            // 2|a|
   localparam int EW  = ((NW + 1 > OW) ? NW + 1 : OW) + 1;
   localparam logic signed [EW-1:0] OUT_MAX_E = EW'((64'sd1 <<< (OW - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] OUT_MIN_E = -OUT_MAX_E - EW'(1);

   typedef struct packed {
      qrs_pkg::kind_type       kind;
      logic                    aneg;
      logic signed [PW-1:0]    p;
      logic [DW-1:0]           d;
   } side_type;

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: capture ----------------
   logic                v1_ff;
   logic signed [W-1:0] a1_ff, b1_ff, c1_ff;

   // ---------------- stage 2: products ----------------
   logic                  v2_ff;
   logic signed [W-1:0]   a2_ff, b2_ff;
   logic signed [2*W-1:0] bb2_ff, ac2_ff;

   // ---------------- stage 3: discriminant ----------------
   logic                  v3_ff;
   logic [MW-1:0]         mag3_ff;
   side_type              side3_ff;
   logic signed [DCW-1:0] disc_in;
   logic [MW-1:0]         mag_in;
   side_type              side_in;

   always_comb begin
      logic signed [PW-1:0] b_e;
      logic [DW-1:0]        a_abs;
      disc_in = DCW'(bb2_ff) - (DCW'(ac2_ff) <<< 2);
      mag_in  = disc_in[DCW-1] ? MW'(-disc_in) : MW'(disc_in);
      b_e     = PW'(b2_ff);
      a_abs   = a2_ff[W-1] ? DW'(-DW'(a2_ff)) : DW'(a2_ff);
      side_in.aneg = a2_ff[W-1];
      side_in.p    = a2_ff[W-1] ? (b_e <<< F) : -(b_e <<< F);
      side_in.d    = DW'(a_abs << 1);
      if (a2_ff == '0)
         side_in.kind = qrs_pkg::KIND_DEGEN;
      else if (disc_in == '0)
         side_in.kind = qrs_pkg::KIND_REPEAT;
      else if (disc_in[DCW-1])
         side_in.kind = qrs_pkg::KIND_COMPLEX;
      else
         side_in.kind = qrs_pkg::KIND_TWO;
   end

   // ---------------- square root stages, one root bit each ----------------
   logic            sv_ff   [RW];
   logic [SW-1:0]   sx_ff   [RW];
   logic [RW+1:0]   srem_ff [RW];
   logic [RW-1:0]   sroot_ff[RW];
   side_type        sside_ff[RW];
   logic            sv_i    [RW];
   logic [SW-1:0]   sx_i    [RW];
   logic [RW+1:0]   srem_i  [RW];
   logic [RW-1:0]   sroot_i [RW];
   side_type        sside_i [RW];
   logic [RW+1:0]   srem_in [RW];
   logic [RW-1:0]   sroot_in[RW];

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      if (k == 0) begin : g_first
         assign sv_i[k]    = v3_ff;
         assign sx_i[k]    = SW'(mag3_ff) << (2*F);
         assign srem_i[k]  = '0;
         assign sroot_i[k] = '0;
         assign sside_i[k] = side3_ff;
      end else begin : g_next
         assign sv_i[k]    = sv_ff[k-1];
         assign sx_i[k]    = sx_ff[k-1];
         assign srem_i[k]  = srem_ff[k-1];
         assign sroot_i[k] = sroot_ff[k-1];
         assign sside_i[k] = sside_ff[k-1];
      end

      always_comb begin
         logic [RW+3:0] rem_sh;
         logic [RW+3:0] trial;
         rem_sh = {srem_i[k], sx_i[k][SW-1-2*k -: 2]};
         trial  = (RW+4)'({sroot_i[k], 2'b01});
         if (rem_sh >= trial) begin
            srem_in[k]  = (RW+2)'(rem_sh - trial);
            sroot_in[k] = {sroot_i[k][RW-2:0], 1'b1};
         end else begin
            srem_in[k]  = (RW+2)'(rem_sh);
            sroot_in[k] = {sroot_i[k][RW-2:0], 1'b0};
         end
      end
   end

   // ---------------- numerator stage ----------------
   function automatic logic [NW:0] numer(input logic signed [PW-1:0] p,
                                         input logic s_neg,
                                         input logic [RW-1:0] r,
                                         input logic inx);
      logic signed [NSW-1:0] pe, re, ie, fl, ce, mg;
      pe = NSW'(p);
      re = signed'(NSW'(r));
      ie = signed'(NSW'(inx));
      if (!s_neg) begin
         fl = pe + re;
         ce = fl + ie;
      end else begin
         ce = pe - re;
         fl = ce - ie;
      end
      mg = fl[NSW-1] ? -ce : fl;
      return {fl[NSW-1], mg[NW-1:0]};
   endfunction

   logic              ev_ff;
   qrs_pkg::kind_type ekind_ff;
   logic [NW-1:0]     en1_ff, en2_ff;
   logic              eneg1_ff, eneg2_ff;
   logic [DW-1:0]     ed_ff;
   logic [NW:0]       num1_in, num2_in;

   always_comb begin
      side_type             s;
      logic                 cplx, inx;
      logic [RW-1:0]        r;
      s    = sside_ff[RW-1];
      r    = sroot_ff[RW-1];
      inx  = srem_ff[RW-1] != '0;
      cplx = s.kind == qrs_pkg::KIND_COMPLEX;
      // first: (-b +/- sqrt)/2a, or real part -b/2a for a complex pair
      num1_in = numer(s.p, cplx ? 1'b0 : s.aneg, cplx ? '0 : r, cplx ? 1'b0 : inx);
      // second: other root, or sqrt(-D)/2a carrying the sign of a
      num2_in = numer(cplx ? '0 : s.p, cplx ? s.aneg : !s.aneg, r, inx);
   end

   // ---------------- divider stages, one quotient bit each ----------------
   logic             dv_ff   [NW];
   qrs_pkg::kind_type dkind_ff[NW];
   logic [DW-1:0]    dd_ff   [NW];
   logic [NW-1:0]    dn1_ff  [NW], dn2_ff [NW];
   logic             dneg1_ff[NW], dneg2_ff[NW];
   logic [DW-1:0]    dr1_ff  [NW], dr2_ff [NW];
   logic [NW-1:0]    dq1_ff  [NW], dq2_ff [NW];
   logic             dv_i    [NW];
   qrs_pkg::kind_type dkind_i [NW];
   logic [DW-1:0]    dd_i    [NW];
   logic [NW-1:0]    dn1_i   [NW], dn2_i  [NW];
   logic             dneg1_i [NW], dneg2_i [NW];
   logic [DW-1:0]    dr1_i   [NW], dr2_i  [NW];
   logic [NW-1:0]    dq1_i   [NW], dq2_i  [NW];
   logic [DW-1:0]    dr1_in  [NW], dr2_in [NW];
   logic [NW-1:0]    dq1_in  [NW], dq2_in [NW];

   for (genvar j = 0; j < NW; j++) begin : g_div
      if (j == 0) begin : g_first
         assign dv_i[j]    = ev_ff;
         assign dkind_i[j] = ekind_ff;
         assign dd_i[j]    = ed_ff;
         assign dn1_i[j]   = en1_ff;
         assign dn2_i[j]   = en2_ff;
         assign dneg1_i[j] = eneg1_ff;
         assign dneg2_i[j] = eneg2_ff;
         assign dr1_i[j]   = '0;
         assign dr2_i[j]   = '0;
         assign dq1_i[j]   = '0;
         assign dq2_i[j]   = '0;
      end else begin : g_next
         assign dv_i[j]    = dv_ff[j-1];
         assign dkind_i[j] = dkind_ff[j-1];
         assign dd_i[j]    = dd_ff[j-1];
         assign dn1_i[j]   = dn1_ff[j-1];
         assign dn2_i[j]   = dn2_ff[j-1];
         assign dneg1_i[j] = dneg1_ff[j-1];
         assign dneg2_i[j] = dneg2_ff[j-1];
         assign dr1_i[j]   = dr1_ff[j-1];
         assign dr2_i[j]   = dr2_ff[j-1];
         assign dq1_i[j]   = dq1_ff[j-1];
         assign dq2_i[j]   = dq2_ff[j-1];
      end

      always_comb begin
         logic [DW:0] t1, t2;
         t1 = {dr1_i[j], dn1_i[j][NW-1-j]};
         t2 = {dr2_i[j], dn2_i[j][NW-1-j]};
         if (t1 >= {1'b0, dd_i[j]}) begin
            dr1_in[j] = DW'(t1 - {1'b0, dd_i[j]});
            dq1_in[j] = {dq1_i[j][NW-2:0], 1'b1};
         end else begin
            dr1_in[j] = DW'(t1);
            dq1_in[j] = {dq1_i[j][NW-2:0], 1'b0};
         end
         if (t2 >= {1'b0, dd_i[j]}) begin
            dr2_in[j] = DW'(t2 - {1'b0, dd_i[j]});
            dq2_in[j] = {dq2_i[j][NW-2:0], 1'b1};
         end else begin
            dr2_in[j] = DW'(t2);
            dq2_in[j] = {dq2_i[j][NW-2:0], 1'b0};
         end
      end
   end

   // ---------------- output stage: sign, saturate, degenerate ----------------
   logic                    rsp_valid_ff;
   qrs_pkg::kind_type       rsp_kind_ff;
   logic signed [OW-1:0]    rsp_first_ff, rsp_second_ff;
   logic signed [OW-1:0]    first_in, second_in;

   function automatic logic signed [OW-1:0] finish(input logic [NW-1:0] q,
                                                   input logic neg);
      logic signed [EW-1:0] qe, res;
      qe  = signed'(EW'(q));
      res = neg ? -qe : qe;
      if (res > OUT_MAX_E)
         res = OUT_MAX_E;
      if (res < OUT_MIN_E)
         res = OUT_MIN_E;
      return OW'(res);
   endfunction

   always_comb begin
      if (dkind_ff[NW-1] == qrs_pkg::KIND_DEGEN) begin
         first_in  = '0;
         second_in = '0;
      end else begin
         first_in  = finish(dq1_ff[NW-1], dneg1_ff[NW-1]);
         second_in = finish(dq2_ff[NW-1], dneg2_ff[NW-1]);
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         ev_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < RW; k++)
            sv_ff[k] <= 1'b0;
         for (int j = 0; j < NW; j++)
            dv_ff[j] <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         ev_ff        <= sv_ff[RW-1];
         rsp_valid_ff <= dv_ff[NW-1];
         for (int k = 0; k < RW; k++)
            sv_ff[k] <= sv_i[k];
         for (int j = 0; j < NW; j++)
            dv_ff[j] <= dv_i[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff    <= req_coef_quad;
         b1_ff    <= req_coef_lin;
         c1_ff    <= req_coef_const;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         bb2_ff   <= b1_ff * b1_ff;
         ac2_ff   <= a1_ff * c1_ff;
         mag3_ff  <= mag_in;
         side3_ff <= side_in;
         for (int k = 0; k < RW; k++) begin
            sx_ff[k]    <= sx_i[k];
            srem_ff[k]  <= srem_in[k];
            sroot_ff[k] <= sroot_in[k];
            sside_ff[k] <= sside_i[k];
         end
         ekind_ff <= sside_ff[RW-1].kind;
         ed_ff    <= sside_ff[RW-1].d;
         en1_ff   <= num1_in[NW-1:0];
         eneg1_ff <= num1_in[NW];
         en2_ff   <= num2_in[NW-1:0];
         eneg2_ff <= num2_in[NW];
         for (int j = 0; j < NW; j++) begin
            dkind_ff[j] <= dkind_i[j];
            dd_ff[j]    <= dd_i[j];
            dn1_ff[j]   <= dn1_i[j];
            dn2_ff[j]   <= dn2_i[j];
            dneg1_ff[j] <= dneg1_i[j];
            dneg2_ff[j] <= dneg2_i[j];
            dr1_ff[j]   <= dr1_in[j];
            dr2_ff[j]   <= dr2_in[j];
            dq1_ff[j]   <= dq1_in[j];
            dq2_ff[j]   <= dq2_in[j];
         end
         rsp_kind_ff   <= dkind_ff[NW-1];
         rsp_first_ff  <= first_in;
         rsp_second_ff <= second_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_root_kind    = rsp_kind_ff;
   assign rsp_first_value  = rsp_first_ff;
   assign rsp_second_value = rsp_second_ff;

   // ---------------- assertions ----------------
   `QRS_ASSERT_NOW(a_degen_zero, clock, reset,
      rsp_valid && rsp_kind_ff == qrs_pkg::KIND_DEGEN,
      rsp_first_value == '0 && rsp_second_value == '0, "degenerate result not zero")
   `QRS_ASSERT_NOW(a_repeat_equal, clock, reset,
      rsp_valid && rsp_kind_ff == qrs_pkg::KIND_REPEAT,
      rsp_first_value == rsp_second_value, "repeated root values differ")
   `QRS_ASSERT_NOW(a_stall_blocks, clock, reset,
      rsp_valid && !rsp_ready, !req_ready, "input taken during output stall")
   `QRS_ASSERT_NEXT(a_stall_holds_pipe, clock, reset,
      rsp_valid && !rsp_ready, $stable(ev_ff) && $stable(v3_ff), "pipe moved during stall")

endmodule

@@ bench/tb.sv @@
// Self-checking bench for quadratic_root_solver: coefficient transfers in, root transfers out.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = qrs_pkg::COEF_WIDTH_DEF;
   localparam int FB          = qrs_pkg::FRAC_BITS_DEF;
   localparam int OWB         = qrs_pkg::OUT_WIDTH;
   localparam int N_RANDOM    = 1900;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 120;   // extra wait after the last expected result

   typedef struct {
      logic signed [CW-1:0] quad;
      logic signed [CW-1:0] lin;
      logic signed [CW-1:0] cnst;
   } coef_set_type;

   typedef struct {
      qrs_pkg::kind_type     kind;
      logic [OWB-1:0]        first;
      logic [OWB-1:0]        second;
   } roots_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_coef_quad = '0;
   logic signed [CW-1:0] req_coef_lin = '0;
   logic signed [CW-1:0] req_coef_const = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_root_kind;
   logic signed [OWB-1:0] rsp_first_value;
   logic signed [OWB-1:0] rsp_second_value;

   quadratic_root_solver dut (.*);

   always #10 clock = ~clock;

   coef_set_type pending_coefs[$];
   roots_type    expected_roots[$];
   int        n_queued = 0;
   int        n_sent = 0;
   int        n_errors = 0;
   int        idle_cycles = 0;
   bit        req_taken = 0;
   bit        rsp_taken = 0;
   bit        calm = 0;       // stretch with no idling on either side
   int        req_gap = 0;
   int        rsp_stall = 0;

   // floor(sqrt(m * 2^(2*FB))) and whether it was exact
   function automatic logic [63:0] scaled_root(input logic [63:0] m, output bit inexact);
      logic [159:0] val, t, root;
      val = {96'b0, m} << (2 * FB);
      root = '0;
      for (int i = 40; i >= 0; i--) begin
         t = root | (160'b1 << i);
         if (t * t <= val) root = t;
      end
      inexact = (root * root != val);
      return root[63:0];
   endfunction

   // trunc((p + sgn*s)/d), d > 0, floor(s) = r, saturated to the output range
   function automatic longint trunc_div(input longint p, input int sgn, input longint r,
                                        input bit inexact, input longint d);
      longint fl, ce, res, hi, lo;
      hi = (longint'(1) <<< (OWB - 1)) - 1;
      lo = -hi - 1;
      if (sgn > 0) begin
         fl = p + r;
         ce = fl + inexact;
      end else begin
         ce = p - r;
         fl = ce - inexact;
      end
      if (fl >= 0) res = fl / d;
      else res = -((-ce) / d);
      if (res > hi) res = hi;
      if (res < lo) res = lo;
      return res;
   endfunction

   function automatic roots_type solve_roots(input coef_set_type cs);
      roots_type o;
      longint  a, b, c, disc, p, d, v1, v2, r;
      int      sgn;
      bit      inexact;
      a = cs.quad;
      b = cs.lin;
      c = cs.cnst;
      o.kind = qrs_pkg::KIND_DEGEN;
      o.first = '0;
      o.second = '0;
      if (a == 0) return o;
      disc = b * b - 4 * a * c;
      p = -b * (longint'(1) <<< FB);
      sgn = 1;
      if (a < 0) begin
         p = -p;
         sgn = -1;
         d = -a * 2;
      end else begin
         d = a * 2;
      end
      r = longint'(scaled_root(disc < 0 ? -disc : disc, inexact));
      if (disc == 0) begin
         o.kind = qrs_pkg::KIND_REPEAT;
         v1 = trunc_div(p, 1, 0, 0, d);
         v2 = v1;
      end else if (disc > 0) begin
         o.kind = qrs_pkg::KIND_TWO;
         v1 = trunc_div(p, sgn, r, inexact, d);
         v2 = trunc_div(p, -sgn, r, inexact, d);
      end else begin
         o.kind = qrs_pkg::KIND_COMPLEX;
         v1 = trunc_div(p, 1, 0, 0, d);
         v2 = trunc_div(0, sgn, r, inexact, d);
      end
      o.first = v1[OWB-1:0];
      o.second = v2[OWB-1:0];
      return o;
   endfunction

   task automatic queue_coefs(input int qa, input int qb, input int qc);
      coef_set_type cs;
      cs.quad = qa[CW-1:0];
      cs.lin = qb[CW-1:0];
      cs.cnst = qc[CW-1:0];
      pending_coefs.push_back(cs);
      n_queued++;
   endtask

   function automatic int small_coef(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // Driver: new coefficients at the falling edge once the previous transfer is done.
   always @(negedge clock) begin
      coef_set_type cs;
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_coefs.size() > 0) begin
            cs = pending_coefs.pop_front();
            req_coef_quad <= cs.quad;
            req_coef_lin <= cs.lin;
            req_coef_const <= cs.cnst;
            req_valid <= 1'b1;
            req_gap = calm ? 0 : $urandom_range(0, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 0;
      // result-side backpressure, one draw per result
      if (!reset) begin
         if (rsp_taken) rsp_stall = calm ? 0 : $urandom_range(0, 13);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
      rsp_taken = 0;
      if ($urandom_range(0, 199) == 0) calm = ~calm;
   end

   // Monitor: predict on each input transfer, check each output transfer.
   always @(posedge clock) begin
      roots_type exp_r;
      coef_set_type cs;
      if (!reset) begin
         if (req_valid && req_ready) begin
            cs.quad = req_coef_quad;
            cs.lin = req_coef_lin;
            cs.cnst = req_coef_const;
            expected_roots.push_back(solve_roots(cs));
            req_taken = 1;
            n_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1;
            if (expected_roots.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected result transfer kind=%0d", rsp_root_kind);
            end else begin
               exp_r = expected_roots.pop_front();
               if (rsp_root_kind !== exp_r.kind || rsp_first_value !== exp_r.first ||
                   rsp_second_value !== exp_r.second) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display({"mismatch: exp kind=%0d first=%h second=%h",
                               " got kind=%0d first=%h second=%h"},
                              exp_r.kind, exp_r.first, exp_r.second,
                              rsp_root_kind, rsp_first_value, rsp_second_value);
               end
            end
         end
         // watchdog on cycles with no transfer at all
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int a, m, k;
      // directed: degenerate, extremes, each root kind, both signs of a
      queue_coefs(0, 0, 0);
      queue_coefs(0, 32767, -32768);
      queue_coefs(-32768, -32768, -32768);
      queue_coefs(32767, 32767, 32767);
      queue_coefs(-32768, 32767, 32767);
      queue_coefs(32767, -32768, -32768);
      queue_coefs(-32768, 0, 32767);
      queue_coefs(32767, 0, -32768);
      queue_coefs(1, -32768, 0);
      queue_coefs(1, 32767, -32768);
      queue_coefs(1, -2, 1);
      queue_coefs(-1, 2, -1);
      queue_coefs(4, 4, 1);
      queue_coefs(1, 0, -1);
      queue_coefs(1, 0, -2);
      queue_coefs(-3, 7, 5);
      queue_coefs(1, 0, 1);
      queue_coefs(-1, 1, -1);
      queue_coefs(2, 3, 5);
      queue_coefs(-1, 0, 0);
      queue_coefs(1, -1, 0);
      queue_coefs(32767, 1, 32767);
      queue_coefs(-32768, 1, -32768);
      // random: full range, small values, repeated roots, degenerate
      for (int i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: queue_coefs($urandom, $urandom, $urandom);
            4, 5, 6: queue_coefs(small_coef(20), small_coef(40), small_coef(20));
            7, 8: begin
               a = small_coef(60);
               m = small_coef(60);
               k = $urandom_range(0, 1);
               queue_coefs(a, 2 * a * m, a * m * m + k);
            end
            default: queue_coefs(0, $urandom, $urandom);
         endcase
      end
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      while (n_sent != n_queued) @(posedge clock);
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (n_errors == 0 && expected_roots.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
